// ----- sv/wkat_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the white key alpha tint block.
// Used by every module of the block; depends on nothing else.
package wkat_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned SumW    = 10;
  localparam int unsigned GainW   = 24;
  localparam int unsigned WeightW = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned RampProdW = SumW + GainW;
  localparam int unsigned RampShift = 16;
  localparam int unsigned BlendW = ChanW + WeightW;

  localparam logic [WeightW-1:0] WeightOne = 11'd1024;

  localparam logic [ChanW-1:0]    HardBrightRst = 8'd235;
  localparam logic [ChanW-1:0]    SoftBrightRst = 8'd215;
  localparam logic [ChanW-1:0]    HardSatRst    = 8'd20;
  localparam logic [ChanW-1:0]    SoftSatRst    = 8'd30;
  localparam logic [GainW-1:0]    RampGainRst   = 24'd278528;
  localparam logic [GainW-1:0]    TintColorRst  = 24'h7B73AD;
  localparam logic [WeightW-1:0]  TintWeightRst = 11'd82;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HARD_BRIGHTNESS = 3'd0,
    REG_SOFT_BRIGHTNESS = 3'd1,
    REG_HARD_SATURATION = 3'd2,
    REG_SOFT_SATURATION = 3'd3,
    REG_RAMP_GAIN       = 3'd4,
    REG_TINT_COLOR      = 3'd5,
    REG_TINT_WEIGHT     = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [ChanW-1:0]   hard_brightness;
    logic [ChanW-1:0]   soft_brightness;
    logic [ChanW-1:0]   hard_saturation;
    logic [ChanW-1:0]   soft_saturation;
    logic [GainW-1:0]   ramp_gain;
    logic [GainW-1:0]   tint_color;
    logic [WeightW-1:0] tint_weight;
  } cfg_t;

  typedef enum logic [1:0] {
    ALPHA_CLEAR,
    ALPHA_RAMP,
    ALPHA_OPAQUE
  } alpha_mode_t;

endpackage

// ----- sv/wkat_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file of the white key alpha tint block.
// Depends on wkat_pkg for the register layout and reset values.
module wkat_cfg_regs import wkat_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hard_brightness <= HardBrightRst;
      cfg.soft_brightness <= SoftBrightRst;
      cfg.hard_saturation <= HardSatRst;
      cfg.soft_saturation <= SoftSatRst;
      cfg.ramp_gain       <= RampGainRst;
      cfg.tint_color      <= TintColorRst;
      cfg.tint_weight     <= TintWeightRst;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HARD_BRIGHTNESS: cfg.hard_brightness <= cfg_data[ChanW-1:0];
        REG_SOFT_BRIGHTNESS: cfg.soft_brightness <= cfg_data[ChanW-1:0];
        REG_HARD_SATURATION: cfg.hard_saturation <= cfg_data[ChanW-1:0];
        REG_SOFT_SATURATION: cfg.soft_saturation <= cfg_data[ChanW-1:0];
        REG_RAMP_GAIN:       cfg.ramp_gain       <= cfg_data[GainW-1:0];
        REG_TINT_COLOR:      cfg.tint_color      <= cfg_data[GainW-1:0];
        REG_TINT_WEIGHT:     cfg.tint_weight     <= cfg_data[WeightW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/wkat_key.sv -----
`timescale 1ns / 1ps
// Alpha path: brightness and saturation test, ramp multiply and clamp.
// Purely combinational; the top registers its input and its result.
// Depends on wkat_pkg.
module wkat_key import wkat_pkg::*; (
  input  cfg_t             cfg,
  input  logic [ChanW-1:0] red,
  input  logic [ChanW-1:0] green,
  input  logic [ChanW-1:0] blue,
  output logic [ChanW-1:0] alpha
);

  logic [SumW-1:0]      sum;
  logic [ChanW-1:0]     max_c;
  logic [ChanW-1:0]     min_c;
  logic [ChanW-1:0]     sat;
  logic [SumW-1:0]      hard_top;
  logic [SumW-1:0]      soft_top;
  alpha_mode_t          mode;
  logic [SumW-1:0]      diff;
  logic [RampProdW-1:0] prod;
  logic [RampProdW-RampShift-1:0] ramp;

  always_comb begin
    sum = SumW'(red) + SumW'(green) + SumW'(blue);
    max_c = red;
    min_c = red;
    if (green > max_c) max_c = green;
    if (blue > max_c)  max_c = blue;
    if (green < min_c) min_c = green;
    if (blue < min_c)  min_c = blue;
    sat = max_c - min_c;
    hard_top = SumW'(cfg.hard_brightness) * SumW'(3);
    soft_top = SumW'(cfg.soft_brightness) * SumW'(3);
    // A ramp case at or above the hard threshold would go negative: clear it.
    priority if (sum > hard_top && sat < cfg.hard_saturation) begin
      mode = ALPHA_CLEAR;
    end else if (sum > soft_top && sat < cfg.soft_saturation) begin
      mode = (sum >= hard_top) ? ALPHA_CLEAR : ALPHA_RAMP;
    end else begin
      mode = ALPHA_OPAQUE;
    end
  end

  assign diff = hard_top - sum;
  assign prod = RampProdW'(diff) * RampProdW'(cfg.ramp_gain);
  assign ramp = prod[RampProdW-1:RampShift];

  always_comb begin
    unique case (mode)
      ALPHA_CLEAR:  alpha = '0;
      ALPHA_RAMP:   alpha = (ramp > (RampProdW-RampShift)'(8'hFF)) ? 8'hFF
                                                                   : ramp[ChanW-1:0];
      ALPHA_OPAQUE: alpha = 8'hFF;
      default:      alpha = 8'hFF;
    endcase
  end

endmodule

// ----- sv/wkat_tint.sv -----
`timescale 1ns / 1ps
// Color path: blends each channel toward the tint color.
// Purely combinational. Depends on wkat_pkg.
module wkat_tint import wkat_pkg::*; (
  input  cfg_t             cfg,
  input  logic [ChanW-1:0] red,
  input  logic [ChanW-1:0] green,
  input  logic [ChanW-1:0] blue,
  output logic [ChanW-1:0] red_t,
  output logic [ChanW-1:0] green_t,
  output logic [ChanW-1:0] blue_t
);

  logic [WeightW-1:0] w;
  logic [WeightW-1:0] w_inv;

  function automatic logic [ChanW-1:0] blend(input logic [ChanW-1:0]   c,
                                             input logic [ChanW-1:0]   t,
                                             input logic [WeightW-1:0] wc,
                                             input logic [WeightW-1:0] wt);
    logic [BlendW-1:0] acc;
    acc = BlendW'(c) * BlendW'(wc) + BlendW'(t) * BlendW'(wt);
    return acc[ChanW+9:10];
  endfunction

  assign w     = (cfg.tint_weight > WeightOne) ? WeightOne : cfg.tint_weight;
  assign w_inv = WeightOne - w;

  assign red_t   = blend(red,   cfg.tint_color[23:16], w_inv, w);
  assign green_t = blend(green, cfg.tint_color[15:8],  w_inv, w);
  assign blue_t  = blend(blue,  cfg.tint_color[7:0],   w_inv, w);

endmodule

// ----- sv/white_key_alpha_tint.sv -----
`timescale 1ns / 1ps
// White key with soft alpha ramp and color tint, top level.
// Instantiates wkat_cfg_regs, wkat_key and wkat_tint; depends on wkat_pkg.
//
// Usage:
//   A pixel transfer happens at a rising edge with start high and busy low.
//   busy is always low, so one pixel can be taken every cycle.
//   Each pixel yields one RGBA result on red_out, green_out, blue_out and
//   alpha_out, marked by done for exactly one cycle. done and the result
//   are registered together after the input register, with the key and
//   blend logic between the two, and the throughput is one pixel per
//   cycle, since every pixel passes the combinational logic without a stall.
//   The receiver cannot stall; every result must be taken as it appears.
//   Registers are written through cfg_write, cfg_index and cfg_data in the
//   cycle that cfg_write is high; unknown indexes are ignored. Write them
//   only while no pixel is in flight.
//   Synchronous reset rst empties the pipeline and loads the register
//   defaults.
module white_key_alpha_tint import wkat_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [ChanW-1:0]    red_in,
  input  logic [ChanW-1:0]    green_in,
  input  logic [ChanW-1:0]    blue_in,
  output logic                done,
  output logic [ChanW-1:0]    red_out,
  output logic [ChanW-1:0]    green_out,
  output logic [ChanW-1:0]    blue_out,
  output logic [ChanW-1:0]    alpha_out,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t             cfg;
  logic [ChanW-1:0] red_q, green_q, blue_q;
  logic             valid_q;
  logic [ChanW-1:0] alpha_b;
  logic [ChanW-1:0] red_b, green_b, blue_b;

  assign busy = 1'b0;

  wkat_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      done    <= 1'b0;
    end else begin
      valid_q <= start & ~busy;
      done    <= valid_q;
    end
  end

  always_ff @(posedge clk) begin
    red_q     <= red_in;
    green_q   <= green_in;
    blue_q    <= blue_in;
    red_out   <= red_b;
    green_out <= green_b;
    blue_out  <= blue_b;
    alpha_out <= alpha_b;
  end

  wkat_key u_key (
    .cfg   (cfg),
    .red   (red_q),
    .green (green_q),
    .blue  (blue_q),
    .alpha (alpha_b)
  );

  wkat_tint u_tint (
    .cfg     (cfg),
    .red     (red_q),
    .green   (green_q),
    .blue    (blue_q),
    .red_t   (red_b),
    .green_t (green_b),
    .blue_t  (blue_b)
  );

endmodule

// ----- bench/tb_white_key_alpha_tint.sv -----
`timescale 1ns / 1ps
// Self-checking bench for white_key_alpha_tint: pixel driver, result monitor and a
// bit-exact predictor of the key alpha and tint blend. Depends on wkat_pkg and the RTL.
module tb_white_key_alpha_tint;
  import wkat_pkg::*;

  localparam int unsigned ResetCycles = 7;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned WeightShift = 10;
  localparam logic [ChanW-1:0] AlphaClear  = 8'd0;
  localparam logic [ChanW-1:0] AlphaOpaque = 8'd255;
  localparam logic [CfgIdxW-1:0] RegSpare  = 3'd7;
  localparam cfg_t ResetCfg = '{HardBrightRst, SoftBrightRst, HardSatRst, SoftSatRst,
                                RampGainRst, TintColorRst, TintWeightRst};

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } rgba_t;

  typedef enum logic [1:0] {
    ACT_PIXEL,
    ACT_CONFIG,
    ACT_SETTLE
  } action_t;

  typedef struct {
    action_t            act;
    int unsigned        idle;
    logic [ChanW-1:0]   red;
    logic [ChanW-1:0]   green;
    logic [ChanW-1:0]   blue;
    logic [CfgIdxW-1:0] idx;
    logic [CfgDataW-1:0] value;
  } stim_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [ChanW-1:0]    red_in = '0;
  logic [ChanW-1:0]    green_in = '0;
  logic [ChanW-1:0]    blue_in = '0;
  logic                done;
  logic [ChanW-1:0]    red_out;
  logic [ChanW-1:0]    green_out;
  logic [ChanW-1:0]    blue_out;
  logic [ChanW-1:0]    alpha_out;
  logic                cfg_write = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  stim_t       stim_q[$];
  rgba_t       due_rgba[int];
  int          pixels_sent = 0;
  int          pixels_out = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  cfg_t        plan_cfg;

  white_key_alpha_tint u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .done      (done),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .alpha_out (alpha_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cfg_t write_reg(input cfg_t c, input logic [CfgIdxW-1:0] idx,
                                     input logic [CfgDataW-1:0] v);
    case (idx)
      REG_HARD_BRIGHTNESS: c.hard_brightness = v[ChanW-1:0];
      REG_SOFT_BRIGHTNESS: c.soft_brightness = v[ChanW-1:0];
      REG_HARD_SATURATION: c.hard_saturation = v[ChanW-1:0];
      REG_SOFT_SATURATION: c.soft_saturation = v[ChanW-1:0];
      REG_RAMP_GAIN:       c.ramp_gain = v[GainW-1:0];
      REG_TINT_COLOR:      c.tint_color = v[GainW-1:0];
      REG_TINT_WEIGHT:     c.tint_weight = v[WeightW-1:0];
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [ChanW-1:0] blend_chan(input logic [ChanW-1:0] c,
                                                  input logic [ChanW-1:0] t,
                                                  input int unsigned w);
    int unsigned mix;
    mix = (c * (WeightOne - w) + t * w) >> WeightShift;
    return mix[ChanW-1:0];
  endfunction

  function automatic rgba_t predict_rgba(input cfg_t c, input logic [ChanW-1:0] r,
                                         input logic [ChanW-1:0] g,
                                         input logic [ChanW-1:0] b);
    int unsigned     sum, hi, lo, sat, hard3, soft3, w;
    longint unsigned ramp;
    rgba_t           px;
    sum = r + g + b;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    sat = hi - lo;
    hard3 = 3 * c.hard_brightness;
    soft3 = 3 * c.soft_brightness;
    if (sum > hard3 && sat < c.hard_saturation) begin
      px.alpha = AlphaClear;
    end else if (sum > soft3 && sat < c.soft_saturation) begin
      // At or above the hard level the ramp would go negative, so it clamps to clear.
      if (sum >= hard3) begin
        px.alpha = AlphaClear;
      end else begin
        ramp = hard3 - sum;
        ramp = (ramp * c.ramp_gain) >> RampShift;
        px.alpha = (ramp > AlphaOpaque) ? AlphaOpaque : ramp[ChanW-1:0];
      end
    end else begin
      px.alpha = AlphaOpaque;
    end
    w = (c.tint_weight > WeightOne) ? WeightOne : c.tint_weight;
    px.red   = blend_chan(r, c.tint_color[2*ChanW +: ChanW], w);
    px.green = blend_chan(g, c.tint_color[ChanW +: ChanW], w);
    px.blue  = blend_chan(b, c.tint_color[0 +: ChanW], w);
    return px;
  endfunction

  function automatic logic [ChanW-1:0] clamp_chan(input int v);
    if (v < 0) return '0;
    if (v > 255) return AlphaOpaque;
    return v[ChanW-1:0];
  endfunction

  task automatic queue_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                             input logic [ChanW-1:0] b);
    stim_t       s;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    s.act = ACT_PIXEL;
    s.red = r;
    s.green = g;
    s.blue = b;
    s.idx = '0;
    s.value = '0;
    if (burst_left > 0) begin
      burst_left--;
      s.idle = 0;
    end else if (roll < 5) begin
      burst_left = $urandom_range(16, 64);
      s.idle = 0;
    end else if (roll < 50) begin
      s.idle = 0;
    end else if (roll < 88) begin
      s.idle = $urandom_range(1, 3);
    end else if (roll < 97) begin
      s.idle = $urandom_range(4, 12);
    end else begin
      s.idle = $urandom_range(20, 60);
    end
    stim_q.push_back(s);
  endtask

  task automatic queue_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] v);
    stim_t s;
    s.act = ACT_CONFIG;
    s.idle = 0;
    s.red = '0;
    s.green = '0;
    s.blue = '0;
    s.idx = idx;
    s.value = v;
    stim_q.push_back(s);
    plan_cfg = write_reg(plan_cfg, idx, v);
  endtask

  task automatic queue_setting(input cfg_t c);
    queue_reg(REG_HARD_BRIGHTNESS, CfgDataW'(c.hard_brightness));
    queue_reg(REG_SOFT_BRIGHTNESS, CfgDataW'(c.soft_brightness));
    queue_reg(REG_HARD_SATURATION, CfgDataW'(c.hard_saturation));
    queue_reg(REG_SOFT_SATURATION, CfgDataW'(c.soft_saturation));
    queue_reg(REG_RAMP_GAIN, CfgDataW'(c.ramp_gain));
    queue_reg(REG_TINT_COLOR, CfgDataW'(c.tint_color));
    queue_reg(REG_TINT_WEIGHT, CfgDataW'(c.tint_weight));
  endtask

  task automatic queue_random_setting();
    cfg_t        c;
    int unsigned width, roll;
    c.hard_brightness = $urandom_range(0, 255);
    if ($urandom_range(0, 3) == 0) begin
      c.soft_brightness = $urandom_range(0, 255);
    end else if (c.hard_brightness > 40) begin
      c.soft_brightness = c.hard_brightness - $urandom_range(1, 40);
    end else begin
      c.soft_brightness = $urandom_range(0, c.hard_brightness);
    end
    c.hard_saturation = $urandom_range(0, 60);
    c.soft_saturation = c.hard_saturation + $urandom_range(0, 40);
    if ($urandom_range(0, 4) == 0) c.soft_saturation = $urandom_range(0, 255);
    width = (c.hard_brightness > c.soft_brightness) ?
            c.hard_brightness - c.soft_brightness : 1;
    roll = $urandom_range(0, 9);
    if (roll < 6) c.ramp_gain = 255 * 65536 / (3 * width);
    else c.ramp_gain = $urandom_range(0, 24'hFFFFFF);
    c.tint_color = $urandom_range(0, 24'hFFFFFF);
    if ($urandom_range(0, 6) == 0) c.tint_weight = $urandom_range(0, 2047);
    else c.tint_weight = $urandom_range(0, 1024);
    queue_setting(c);
    if ($urandom_range(0, 3) == 0) queue_reg(RegSpare, $urandom_range(0, 24'hFFFFFF));
  endtask

  // Half the pixels sit near the grey, bright corner so the key and ramp branches get
  // real traffic; the rest are extremes and uniform noise.
  task automatic queue_random_pixels(input int unsigned count);
    int unsigned      n, kind, k;
    int               base, spread, lo;
    logic [ChanW-1:0] ch [3];
    for (n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      lo = (plan_cfg.soft_brightness > 12) ? plan_cfg.soft_brightness - 12 : 0;
      base = $urandom_range(lo, 255);
      spread = ((plan_cfg.soft_saturation > plan_cfg.hard_saturation) ?
                plan_cfg.soft_saturation : plan_cfg.hard_saturation) + 8;
      for (k = 0; k < 3; k++) begin
        if (kind < 5) ch[k] = clamp_chan(base + int'($urandom_range(0, spread)) - spread / 2);
        else if (kind == 5) ch[k] = $urandom_range(0, 1) ? AlphaOpaque : '0;
        else ch[k] = $urandom_range(0, 255);
      end
      queue_pixel(ch[0], ch[1], ch[2]);
    end
  endtask

  task automatic queue_settle();
    stim_t s;
    s.act = ACT_SETTLE;
    s.idle = 0;
    s.red = '0;
    s.green = '0;
    s.blue = '0;
    s.idx = '0;
    s.value = '0;
    stim_q.push_back(s);
  endtask

  // Driver: launches pixels from the pending queue and only writes registers once
  // every earlier pixel has left the pipeline.
  always @(posedge clk) begin : drive_pixels
    cfg_t  live_cfg;
    logic  xfer, start_nxt, write_nxt, quiet;
    stim_t head;
    if (rst) begin
      start <= 1'b0;
      red_in <= '0;
      green_in <= '0;
      blue_in <= '0;
      cfg_write <= 1'b0;
      cfg_index <= '0;
      cfg_data <= '0;
      pixels_sent <= 0;
      live_cfg = ResetCfg;
    end else begin
      xfer = start && !busy;
      start_nxt = start;
      write_nxt = 1'b0;
      if (xfer) begin
        due_rgba[pixels_sent] = predict_rgba(live_cfg, red_in, green_in, blue_in);
        pixels_sent <= pixels_sent + 1;
        start_nxt = 1'b0;
      end
      // Nothing in flight once the result taken at this edge is counted.
      quiet = !start && (pixels_sent == pixels_out + (done ? 1 : 0));
      if (!start_nxt && stim_q.size() != 0) begin
        head = stim_q[0];
        case (head.act)
          ACT_PIXEL: begin
            if (head.idle != 0) begin
              stim_q[0].idle = head.idle - 1;
            end else begin
              red_in <= head.red;
              green_in <= head.green;
              blue_in <= head.blue;
              start_nxt = 1'b1;
              stim_q.delete(0);
            end
          end
          ACT_CONFIG: begin
            if (quiet) begin
              write_nxt = 1'b1;
              cfg_index <= head.idx;
              cfg_data <= head.value;
              live_cfg = write_reg(live_cfg, head.idx, head.value);
              stim_q.delete(0);
            end
          end
          default: begin
            if (quiet) stim_q.delete(0);
          end
        endcase
      end
      start <= start_nxt;
      cfg_write <= write_nxt;
    end
  end

  always @(posedge clk) begin : watch_results
    rgba_t got, want;
    if (!rst && done) begin
      got = '{red_out, green_out, blue_out, alpha_out};
      if (pixels_out >= pixels_sent) begin
        fault_count++;
        if (fault_count <= ReportLimit)
          $display("%0t: result r=%0d g=%0d b=%0d a=%0d with no pixel outstanding",
                   $realtime, got.red, got.green, got.blue, got.alpha);
      end else begin
        want = due_rgba[pixels_out];
        due_rgba.delete(pixels_out);
        if (got !== want) begin
          fault_count++;
          if (fault_count <= ReportLimit)
            $display("%0t: pixel %0d expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                     $realtime, pixels_out, want.red, want.green, want.blue, want.alpha,
                     got.red, got.green, got.blue, got.alpha);
        end
        pixels_out <= pixels_out + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_white_key_alpha_tint: errors");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    int   p;
    plan_cfg = ResetCfg;

    // Reset settings: full key, ramp band, both saturation edges, negative ramp.
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd250, 8'd250, 8'd250);
    queue_pixel(8'd235, 8'd235, 8'd235);
    queue_pixel(8'd230, 8'd230, 8'd230);
    queue_pixel(8'd216, 8'd216, 8'd216);
    queue_pixel(8'd215, 8'd215, 8'd215);
    queue_pixel(8'd255, 8'd255, 8'd230);
    queue_pixel(8'd250, 8'd250, 8'd230);
    queue_pixel(8'd255, 8'd255, 8'd225);
    queue_pixel(8'd255, 8'd0, 8'd0);
    queue_pixel(8'd0, 8'd255, 8'd0);
    queue_pixel(8'd0, 8'd0, 8'd255);
    queue_pixel(8'hAA, 8'h55, 8'hAA);
    queue_pixel(8'h55, 8'hAA, 8'h55);
    queue_settle();

    // Ramp overflow, weight beyond full scale and a write to an unused index.
    queue_reg(REG_RAMP_GAIN, 24'hFFFFFF);
    queue_reg(REG_TINT_WEIGHT, 24'd2047);
    queue_reg(REG_TINT_COLOR, 24'hFFFFFF);
    queue_reg(RegSpare, 24'hFFFFFF);
    queue_pixel(8'd216, 8'd216, 8'd216);
    queue_pixel(8'd230, 8'd230, 8'd230);
    queue_pixel(8'h12, 8'h34, 8'h56);
    queue_reg(REG_TINT_WEIGHT, 24'd1025);
    queue_reg(REG_TINT_COLOR, 24'h000000);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd100, 8'd150, 8'd200);

    queue_setting(ResetCfg);
    queue_random_pixels(100);

    c = '{8'd0, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0, 11'd0};
    queue_setting(c);
    queue_random_pixels(60);
    c = '{8'd255, 8'd255, 8'd255, 8'd255, 24'hFFFFFF, 24'hFFFFFF, WeightOne};
    queue_setting(c);
    queue_random_pixels(60);
    c = '{8'd255, 8'd0, 8'd0, 8'd255, 24'h000100, 24'h5A5A5A, 11'd512};
    queue_setting(c);
    queue_random_pixels(60);

    for (p = 0; p < 8; p++) begin
      queue_random_setting();
      queue_random_pixels(90);
    end
    queue_setting(ResetCfg);
    queue_random_pixels(60);

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (stim_q.size() != 0 || start || pixels_out != pixels_sent);
    repeat (DrainCycles) @(negedge clk);

    if (fault_count == 0 && pixels_out == pixels_sent) begin
      $display("tb_white_key_alpha_tint: clean");
    end else begin
      $display("tb_white_key_alpha_tint: errors");
    end
    $finish;
  end

endmodule
